// File: rtl/tempo_position_tick_clock_unit_macros.svh
// Assertion macros shared by the tempo position tick clock RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef TEMPO_POSITION_TICK_CLOCK_UNIT_MACROS_SVH
`define TEMPO_POSITION_TICK_CLOCK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tpc_pkg.sv
// Package for the tempo position tick clock: widths, reset values, codes,
// sequencer states and small fixed-point helpers. No dependencies.
package tpc_pkg;

    // Field widths and fixed-point formats.
    localparam int POS_W           = 40;
    localparam int TEMPO_W         = 18;
    localparam int SAMP_W          = 16;
    localparam int RATE_W          = 20;
    localparam int POS_FRAC_BITS   = 16;
    localparam int TEMPO_FRAC_BITS = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = POS_W;

    // Advance numerator: samples * tempo scaled to position fraction bits.
    localparam int PROD_W   = SAMP_W + TEMPO_W;
    localparam int NUM_W    = PROD_W + POS_FRAC_BITS;
    // Advance denominator: 60 * rate scaled to tempo fraction bits.
    localparam int RATE60_W = RATE_W + 6;
    localparam int DEN_W    = RATE60_W + TEMPO_FRAC_BITS;

    // Shared divider widths and iteration counts.
    localparam int DVD_W       = (NUM_W > POS_W) ? NUM_W : POS_W;
    localparam int DSR_W       = (DEN_W > POS_W) ? DEN_W : POS_W;
    localparam int CNT_W       = $clog2(DVD_W + 1);
    localparam int DELTA_ITERS = DVD_W;
    localparam int MOD_ITERS   = POS_W;
    localparam int MOD_PAD     = DVD_W - POS_W;

    // Eighth-note index is the position shifted down by one less than the
    // fraction bits (half a quarter note per step).
    localparam int HALF_SHIFT = POS_FRAC_BITS - 1;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = TEMPO_W'(120 << TEMPO_FRAC_BITS);
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(48000);
    localparam logic [RATE60_W-1:0] RATE_MULT  = RATE60_W'(60);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INTERNAL   = 3'd0,
        CFG_RATE       = 3'd1,
        CFG_LOOP_EN    = 3'd2,
        CFG_LOOP_START = 3'd3,
        CFG_LOOP_END   = 3'd4
    } cfg_idx_t;

    // Transport mode chosen for one block.
    typedef enum logic [1:0] {
        MODE_HOST_PLAY,
        MODE_HOST_STOP,
        MODE_INTERNAL
    } mode_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_DELTA_WAIT,
        ST_APPLY,
        ST_MOD,
        ST_MOD_WAIT,
        ST_COMMIT,
        ST_OUT
    } state_t;

    // Divider request and status.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp a sum one bit wider than a position to the position range.
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1])
        begin
            r = v[POS_W] ? POS_MIN : POS_MAX;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // floor(position / 0.5) as a signed index.
    function automatic logic signed [POS_W-1:0] half_index(input logic signed [POS_W-1:0] v);
        return v >>> HALF_SHIFT;
    endfunction

endpackage

// File: rtl/tpc_divider.sv
// Shared restoring divider for the tempo position tick clock, one quotient
// bit per cycle. Depends on tpc_pkg.
module tpc_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tpc_pkg::div_req_t       req,
    input  logic [tpc_pkg::DVD_W-1:0] dividend,
    input  logic [tpc_pkg::DSR_W-1:0] divisor,
    output tpc_pkg::div_stat_t      stat,
    output logic [tpc_pkg::DVD_W-1:0] quotient,
    output logic [tpc_pkg::DSR_W-1:0] remainder
);
    import tpc_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVD_W-1:0] shift_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             fits;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        trial = {rem_reg, shift_reg[DVD_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = !diff[DSR_W];
    end

    // Iteration counter and done pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (req.start)
            begin
                cnt_reg <= req.iters;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            dsr_reg   <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            shift_reg <= {shift_reg[DVD_W-2:0], fits};
            rem_reg   <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

endmodule

// File: rtl/tempo_position_tick_clock_unit.sv
// Top level of the tempo position tick clock: configuration registers,
// transport state, sequencer and output register. Depends on tpc_pkg,
// tpc_divider and tempo_position_tick_clock_unit_macros.svh.
//
// One input transfer describes one audio block; one output transfer returns
// the eighth-note tick flag, the playing flag and the position in Q24.16
// quarter notes. Both channels use valid and stall; a transfer happens on a
// rising edge with valid high and stall low. in_stall is high from the
// accepting edge until the sequencer is back in idle.
// When the host is playing or the sample rate is zero, the sequencer goes
// straight to commit; otherwise the block advance is divided out, and when
// the internal loop wraps, a loop modulo follows before the commit.
// Both divisions use the single shared restoring divider, which produces
// one quotient bit per cycle. One item is worked on at a time.
// The output register holds a finished result while the receiver stalls; the
// next input can be accepted meanwhile, and the sequencer waits at its last
// step only if the output register is still occupied.
// Reset clears the transport state to position zero and tempo 120 bpm and
// loads the default configuration (48 kHz, host transport, loop off).
// Configuration writes take effect at once and belong in idle periods.
`include "tempo_position_tick_clock_unit_macros.svh"

module tempo_position_tick_clock_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tpc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               host_present,
    input  logic                               host_playing,
    input  logic                               host_tempo_valid,
    input  logic [tpc_pkg::TEMPO_W-1:0]        host_tempo,
    input  logic                               host_position_valid,
    input  logic signed [tpc_pkg::POS_W-1:0]   host_position,
    input  logic [tpc_pkg::SAMP_W-1:0]         block_samples,
    input  logic                               transport_running,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               tick,
    output logic                               playing,
    output logic signed [tpc_pkg::POS_W-1:0]   position
);
    import tpc_pkg::*;

    // Configuration registers.
    logic                     internal_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic                     loop_en_reg;
    logic signed [POS_W-1:0]  loop_start_reg;
    logic signed [POS_W-1:0]  loop_end_reg;

    // Transport state.
    logic [TEMPO_W-1:0]       tempo_reg;
    logic signed [POS_W-1:0]  cum_pos_reg;
    logic signed [POS_W-1:0]  last_host_pos_reg;
    logic                     last_host_valid_reg;
    logic signed [POS_W-1:0]  tp_pos_reg;

    // Per-item working registers.
    state_t                   state_reg;
    state_t                   state_next;
    mode_t                    mode_reg;
    logic                     tvalid_reg;
    logic                     pvalid_reg;
    logic                     running_reg;
    logic [TEMPO_W-1:0]       htempo_reg;
    logic signed [POS_W-1:0]  hpos_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic                     no_adv_reg;
    logic signed [POS_W-1:0]  delta_reg;
    logic signed [POS_W-1:0]  next_pos_reg;
    logic                     wrap_reg;
    logic                     tick_res_reg;
    logic                     play_res_reg;

    // Output register.
    logic                     out_valid_reg;
    logic                     tick_out_reg;
    logic                     play_out_reg;
    logic signed [POS_W-1:0]  pos_out_reg;

    // Control and datapath signals.
    logic                     in_xfer;
    logic                     out_free;
    logic                     usable;
    mode_t                    mode_dec;
    div_req_t                 div_req;
    div_stat_t                div_stat;
    logic [DVD_W-1:0]         div_dividend;
    logic [DSR_W-1:0]         div_divisor;
    logic [DVD_W-1:0]         div_quot;
    logic [DSR_W-1:0]         div_rem;
    logic [RATE60_W-1:0]      rate60;
    logic signed [POS_W-1:0]  delta_sat;
    logic signed [POS_W-1:0]  sum_base;
    logic signed [POS_W-1:0]  sum_sat;
    logic                     wrap_hit;
    logic [POS_W-1:0]         over_amt;
    logic [POS_W-1:0]         loop_len;
    logic                     host_tick;
    logic                     tp_tick;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Mode decode from the arriving item and the current configuration.
    always_comb
    begin
        usable = !internal_reg && host_present && (host_tempo_valid || host_position_valid);
        if (usable && host_playing)
        begin
            mode_dec = MODE_HOST_PLAY;
        end
        else if (usable)
        begin
            mode_dec = MODE_HOST_STOP;
        end
        else
        begin
            mode_dec = MODE_INTERNAL;
        end
    end

    // Divider operands: block advance or loop modulo.
    always_comb
    begin
        rate60   = RATE60_W'(rate_reg) * RATE_MULT;
        over_amt = POS_W'(next_pos_reg - loop_end_reg);
        loop_len = POS_W'(loop_end_reg - loop_start_reg);
        if (state_reg == ST_MOD)
        begin
            div_dividend = DVD_W'(over_amt) << MOD_PAD;
            div_divisor  = DSR_W'(loop_len);
        end
        else
        begin
            div_dividend = DVD_W'(prod_reg) << POS_FRAC_BITS;
            div_divisor  = DSR_W'(rate60) << TEMPO_FRAC_BITS;
        end
    end

    // Advance clamp, saturating sum and loop wrap test.
    always_comb
    begin
        if (div_quot[DVD_W-1:POS_W-1] != '0)
        begin
            delta_sat = POS_MAX;
        end
        else
        begin
            delta_sat = POS_W'(div_quot);
        end
        if ((mode_reg == MODE_INTERNAL) && running_reg)
        begin
            sum_base = tp_pos_reg;
        end
        else
        begin
            sum_base = cum_pos_reg;
        end
        sum_sat  = sat_pos({sum_base[POS_W-1], sum_base} + {delta_reg[POS_W-1], delta_reg});
        wrap_hit = (mode_reg == MODE_INTERNAL) && running_reg && loop_en_reg
                   && (loop_end_reg > loop_start_reg) && (tp_pos_reg < loop_end_reg)
                   && (sum_sat >= loop_end_reg);
        host_tick = last_host_valid_reg
                    && (half_index(hpos_reg) > half_index(last_host_pos_reg));
        tp_tick   = half_index(next_pos_reg) > half_index(tp_pos_reg);
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (mode_dec == MODE_HOST_PLAY)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else if (rate_reg == '0)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_DELTA;
                    end
                end
            end
            ST_DELTA:
            begin
                state_next = ST_DELTA_WAIT;
            end
            ST_DELTA_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = wrap_hit ? ST_MOD : ST_COMMIT;
            end
            ST_MOD:
            begin
                state_next = ST_MOD_WAIT;
            end
            ST_MOD_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_stall      = 1'b1;
        div_req.start = 1'b0;
        div_req.iters = CNT_W'(DELTA_ITERS);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_DELTA:
            begin
                div_req.start = 1'b1;
            end
            ST_MOD:
            begin
                div_req.start = 1'b1;
                div_req.iters = CNT_W'(MOD_ITERS);
            end
            ST_DELTA_WAIT, ST_APPLY, ST_MOD_WAIT, ST_COMMIT, ST_OUT:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Shared divider.
    tpc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            internal_reg   <= 1'b0;
            rate_reg       <= RATE_RESET;
            loop_en_reg    <= 1'b0;
            loop_start_reg <= '0;
            loop_end_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INTERNAL:   internal_reg   <= cfg_data[0];
                CFG_RATE:       rate_reg       <= cfg_data[RATE_W-1:0];
                CFG_LOOP_EN:    loop_en_reg    <= cfg_data[0];
                CFG_LOOP_START: loop_start_reg <= cfg_data[POS_W-1:0];
                CFG_LOOP_END:   loop_end_reg   <= cfg_data[POS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Item capture and working values; these need no reset.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg     <= mode_dec;
            tvalid_reg   <= host_tempo_valid;
            pvalid_reg   <= host_position_valid;
            running_reg  <= transport_running;
            htempo_reg   <= host_tempo;
            hpos_reg     <= host_position;
            prod_reg     <= PROD_W'(block_samples) * PROD_W'(tempo_reg);
            no_adv_reg   <= (rate_reg == '0);
            delta_reg    <= '0;
            wrap_reg     <= 1'b0;
        end
        if ((state_reg == ST_DELTA_WAIT) && div_stat.done)
        begin
            delta_reg <= delta_sat;
        end
        if (state_reg == ST_APPLY)
        begin
            next_pos_reg <= sum_sat;
            wrap_reg     <= wrap_hit;
        end
        if ((state_reg == ST_MOD_WAIT) && div_stat.done)
        begin
            next_pos_reg <= loop_start_reg + $signed(div_rem[POS_W-1:0]);
        end
    end

    // Transport state update and per-item result flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg           <= TEMPO_RESET;
            cum_pos_reg         <= '0;
            last_host_pos_reg   <= '0;
            last_host_valid_reg <= 1'b0;
            tp_pos_reg          <= '0;
            tick_res_reg        <= 1'b0;
            play_res_reg        <= 1'b0;
        end
        else if (state_reg == ST_COMMIT)
        begin
            unique case (mode_reg)
                MODE_HOST_PLAY:
                begin
                    play_res_reg <= 1'b1;
                    tick_res_reg <= pvalid_reg && host_tick;
                    if (tvalid_reg)
                    begin
                        tempo_reg <= htempo_reg;
                    end
                    if (pvalid_reg)
                    begin
                        cum_pos_reg         <= hpos_reg;
                        last_host_pos_reg   <= hpos_reg;
                        last_host_valid_reg <= 1'b1;
                    end
                end
                MODE_HOST_STOP:
                begin
                    play_res_reg        <= 1'b0;
                    tick_res_reg        <= 1'b0;
                    last_host_valid_reg <= 1'b0;
                    if (!no_adv_reg)
                    begin
                        cum_pos_reg <= next_pos_reg;
                    end
                end
                MODE_INTERNAL:
                begin
                    play_res_reg        <= running_reg;
                    tick_res_reg        <= !no_adv_reg && running_reg && tp_tick;
                    last_host_valid_reg <= 1'b0;
                    if (!no_adv_reg)
                    begin
                        cum_pos_reg <= next_pos_reg;
                        if (running_reg)
                        begin
                            tp_pos_reg <= next_pos_reg;
                        end
                    end
                end
                default:
                begin
                    tick_res_reg <= 1'b0;
                end
            endcase
        end
    end

    // Output valid: set when a result is loaded, cleared on its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_OUT) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_OUT) && out_free)
        begin
            tick_out_reg <= tick_res_reg;
            play_out_reg <= play_res_reg;
            pos_out_reg  <= cum_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign tick      = tick_out_reg;
    assign playing   = play_out_reg;
    assign position  = pos_out_reg;

    // Checks on the sequencer and the loop wrap.
    `TPC_ASSERT_NXT(a_accept_stalls, in_xfer, in_stall, "input transfer did not start the sequencer")
    `TPC_ASSERT_IMP(a_div_in_wait, div_stat.busy, (state_reg == ST_DELTA_WAIT) || (state_reg == ST_MOD_WAIT), "divider busy outside a wait state")
    `TPC_ASSERT_IMP(a_wrap_in_loop, (state_reg == ST_COMMIT) && wrap_reg, (next_pos_reg < loop_end_reg) && (next_pos_reg >= loop_start_reg), "wrapped position outside the loop range")
    `TPC_ASSERT_IMP(a_out_from_seq, $rose(out_valid_reg), $past(state_reg == ST_OUT), "output valid rose without a finished item")

endmodule
